@@ hw/rtl/bdl_pkg.sv @@
// Shared types and constants for the button debounce / long-press block.
`timescale 1ns / 1ps

package bdl_pkg;

    // Scan timing
    localparam logic [31:0] DEBOUNCE_TIME_MS = 32'd50;
    localparam logic [15:0] LONGPRESS_RESET  = 16'd1000;

    // Configuration port
    localparam int          APB_AW           = 3;
    localparam logic        REG_IDX_LONGPRESS = 1'b0;   // paddr[2] selects the register

    // Event queue
    localparam int          EVQ_DEPTH        = 4;
    localparam int          EVQ_PW           = $clog2(EVQ_DEPTH);
    localparam int          EVQ_CW           = $clog2(EVQ_DEPTH + 1);

    typedef enum logic [2:0] {
        EV_DOWN        = 3'd0,
        EV_UP          = 3'd1,
        EV_CLICK       = 3'd2,
        EV_LONGPRESS   = 3'd3,
        EV_HOLD        = 3'd4,
        EV_UNLONGPRESS = 3'd5
    } t_event_code;

    typedef struct packed {
        t_event_code code;
        logic        last;
    } t_evt;

    // Events produced by one scan, first event in ev0
    typedef struct packed {
        logic [1:0] cnt;
        t_evt       ev0;
        t_evt       ev1;
    } t_push;

endpackage

@@ hw/rtl/bdl_step.sv @@
// Scan input register, debounce/press state and per-scan event decode.
`timescale 1ns / 1ps

module bdl_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tvalid,
    output logic           o_tready,
    input  logic           i_level,
    input  logic [31:0]    i_now,
    input  logic [15:0]    i_delay,
    input  logic           i_room,
    output bdl_pkg::t_push o_push
);
    import bdl_pkg::*;

    // input stage
    logic        r_in_valid;
    logic        r_in_level;
    logic [31:0] r_in_now;

    // button state
    logic        r_prev;
    logic [31:0] r_stable;
    logic [31:0] r_press_start;
    logic        r_press;
    logic        r_long;

    logic        n_prev;
    logic [31:0] n_stable;
    logic [31:0] n_press_start;
    logic        n_press;
    logic        n_long;

    logic        advance;
    logic        take;
    logic [31:0] stable_cur;
    logic [31:0] since_stable;
    logic [31:0] held_ms;
    logic        debounced;
    logic        reached;
    t_push       push;

    assign advance  = r_in_valid & i_room;
    assign o_tready = ~r_in_valid | i_room;
    assign take     = i_tvalid & o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_level <= i_level;
            r_in_now   <= i_now;
        end
    end

    // level change restarts the debounce stamp
    assign stable_cur   = (r_in_level != r_prev) ? r_in_now : r_stable;
    assign since_stable = r_in_now - stable_cur;
    assign debounced    = since_stable > DEBOUNCE_TIME_MS;
    assign held_ms      = r_in_now - r_press_start;
    assign reached      = held_ms >= {16'd0, i_delay};

    always_comb begin
        n_prev        = r_in_level;
        n_stable      = stable_cur;
        n_press_start = r_press_start;
        n_press       = r_press;
        n_long        = r_long;
        push.cnt      = 2'd0;
        push.ev0      = '{code: EV_DOWN, last: 1'b1};
        push.ev1      = '{code: EV_HOLD, last: 1'b1};
        if (debounced) begin
            if (r_in_level) begin
                if (r_press) begin
                    if (!r_long && reached) begin
                        n_long   = 1'b1;
                        push.cnt = 2'd2;
                        push.ev0 = '{code: EV_LONGPRESS, last: 1'b0};
                        push.ev1 = '{code: EV_HOLD, last: 1'b1};
                    end else if (r_long) begin
                        push.cnt = 2'd1;
                        push.ev0 = '{code: EV_HOLD, last: 1'b1};
                    end
                end else begin
                    push.cnt      = 2'd1;
                    push.ev0      = '{code: EV_DOWN, last: 1'b1};
                    n_press_start = r_in_now;
                    n_press       = 1'b1;
                end
            end else if (r_press) begin
                n_press = 1'b0;
                if (!r_long) begin
                    push.cnt = 2'd2;
                    push.ev0 = '{code: EV_UP, last: 1'b0};
                    push.ev1 = '{code: EV_CLICK, last: 1'b1};
                end else begin
                    n_long   = 1'b0;
                    push.cnt = 2'd1;
                    push.ev0 = '{code: EV_UNLONGPRESS, last: 1'b1};
                end
            end
        end
        if (!advance) begin
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= 1'b0;
            r_stable      <= '0;
            r_press_start <= '0;
            r_press       <= 1'b0;
            r_long        <= 1'b0;
        end else if (advance) begin
            r_prev        <= n_prev;
            r_stable      <= n_stable;
            r_press_start <= n_press_start;
            r_press       <= n_press;
            r_long        <= n_long;
        end
    end

`ifndef SYNTHESIS
    a_long_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long |-> r_press)
        else $error("long press flagged without an active press");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0) |-> i_room)
        else $error("events pushed into a full queue");

    a_down_starts_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd1 && o_push.ev0.code == EV_DOWN) |=> (r_press && !r_long))
        else $error("down event did not start a press");

    a_release_ends_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0 && (o_push.ev0.code == EV_UP || o_push.ev0.code == EV_UNLONGPRESS))
        |=> !r_press)
        else $error("release did not end the press");
`endif

endmodule

@@ hw/rtl/bdl_evt_fifo.sv @@
// Event queue: takes up to two events per cycle, delivers one per transfer.
`timescale 1ns / 1ps

module bdl_evt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdl_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output bdl_pkg::t_evt  o_evt
);
    import bdl_pkg::*;

    t_evt              r_mem [EVQ_DEPTH];
    logic [EVQ_PW-1:0] r_wptr;
    logic [EVQ_PW-1:0] r_rptr;
    logic [EVQ_CW-1:0] r_count;
    logic              pop;
    logic [EVQ_PW-1:0] wptr_nx;

    assign o_valid = r_count != '0;
    assign pop     = o_valid & i_ready;
    assign o_room  = r_count <= EVQ_CW'(EVQ_DEPTH - 2);
    assign o_evt   = r_mem[r_rptr];
    assign wptr_nx = r_wptr + EVQ_PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.ev0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wptr_nx] <= i_push.ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + EVQ_PW'(i_push.cnt);
            r_rptr  <= r_rptr + EVQ_PW'(pop);
            r_count <= r_count + EVQ_CW'(i_push.cnt) - EVQ_CW'(pop);
        end
    end

endmodule

@@ hw/rtl/button_debounce_longpress_core.sv @@
// Top level: button debounce with long-press detection, stream in/out, APB config.
`timescale 1ns / 1ps

// Usage:
//  - s_axis carries one scan per transfer: tdata[0] is the sampled pin level,
//    tdata[32:1] the millisecond timestamp (wraps modulo 2^32).
//  - m_axis carries one event per transfer: tdata[2:0] event code
//    (down, up, click, longpress, hold, unlongpress); tlast marks the final
//    event caused by one scan. A scan gives zero, one or two events.
//  - APB register at byte address 0 holds the long-press delay in ms
//    (16 bits, reset 1000). Write it only while no scan is in flight.
// Timing:
//  - A scan is registered into the input register on transfer, decoded
//    combinationally from it, and its events are written into the 4-entry
//    event queue once the queue has room; the first event of a scan is
//    offered from the queue head and a second event follows it.
//  - One scan per cycle is taken as long as the queue has space for two
//    events; the output port drains one event per cycle while m_axis_tready
//    is high, so a sustained stream of two-event scans is throttled by it.
// Reset (synchronous, active low) clears the button state, the queue and
// sets the delay to 1000 ms. When the receiver stalls, events wait in the
// queue; once fewer than two entries are free a scan waits in the input
// register and s_axis_tready drops until the queue has room again.

module button_debounce_longpress_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // scan stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,   // [0] pin_level, [32:1] now_ms
    // event stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [2:0] event_code
    output logic                       m_axis_tlast,   // last_event
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bdl_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bdl_pkg::*;

    logic [15:0] r_delay;
    logic        cfg_wr;
    t_push       push;
    logic        room;
    t_evt        evt;

    // long-press delay register; paddr[2] is the register index
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_LONGPRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= LONGPRESS_RESET;
        end else if (cfg_wr) begin
            r_delay <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_LONGPRESS) ? {16'd0, r_delay} : 32'd0;

    // scan decode
    bdl_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_level  (s_axis_tdata[0]),
        .i_now    (s_axis_tdata[32:1]),
        .i_delay  (r_delay),
        .i_room   (room),
        .o_push   (push)
    );

    // event queue toward the output port
    bdl_evt_fifo u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_evt   (evt)
    );

    assign m_axis_tdata = {5'd0, evt.code};
    assign m_axis_tlast = evt.last;

endmodule
